/* src/utp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_pkg: shared types and constants
// Opcodes, register offsets and control bit positions for the timer.
// ----------------------------------------------------------------------------
package utp_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_POLL  = 2'd3
  } op_t;

  localparam logic [9:0] OFF_CTL  = 10'h00;
  localparam logic [9:0] OFF_PW0  = 10'h04;
  localparam logic [9:0] OFF_PW1  = 10'h08;
  localparam logic [9:0] OFF_IEN  = 10'h0C;
  localparam logic [9:0] OFF_SR   = 10'h10;
  localparam logic [9:0] OFF_EGR  = 10'h14;
  localparam logic [9:0] OFF_PW2  = 10'h18;
  localparam logic [9:0] OFF_PW3  = 10'h1C;
  localparam logic [9:0] OFF_PW4  = 10'h20;
  localparam logic [9:0] OFF_CNT  = 10'h24;
  localparam logic [9:0] OFF_PSC  = 10'h28;
  localparam logic [9:0] OFF_ARR  = 10'h2C;
  localparam logic [9:0] OFF_CC0  = 10'h34;
  localparam logic [9:0] OFF_CC1  = 10'h38;
  localparam logic [9:0] OFF_CC2  = 10'h3C;
  localparam logic [9:0] OFF_CC3  = 10'h40;
  localparam logic [9:0] OFF_PW5  = 10'h48;
  localparam logic [9:0] OFF_PW6  = 10'h4C;

  localparam int CTL_CEN  = 0;
  localparam int CTL_UDIS = 1;
  localparam int CTL_OPM  = 3;
  localparam int CTL_ARPE = 7;

  localparam logic [9:0]  CTL_MASK = 10'h3FF;
  localparam logic [6:0]  IEN_MASK = 7'h5F;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

/* src/utp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_in_if / utp_out_if: item channels
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface utp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  offset;
  logic [31:0] write_data;
  logic [31:0] insns_elapsed;
  modport source (output valid, opcode, offset, write_data, insns_elapsed, input ready);
  modport sink   (input valid, opcode, offset, write_data, insns_elapsed, output ready);
endinterface

interface utp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_fired;
  modport source (output valid, read_data, irq_fired, input ready);
  modport sink   (input valid, read_data, irq_fired, output ready);
endinterface

/* src/utp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_div: shared restoring divider
// One quotient bit per cycle, 32 quotient bits per divide.
// ----------------------------------------------------------------------------
module utp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  utp_pkg::div_req_t req,
  output utp_pkg::div_rsp_t rsp
);
  import utp_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dsr_r, dsr_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[31]} - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = {15'd0, rem_r};
endmodule

/* src/upcounting_timer_with_prescaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcounting_timer_with_prescaler: up-counting timer with prescaler
// Register bus timer; tick slices divide through a shared serial divider.
//
//   channel | dir | payload
//   in_     | in  | opcode, offset, write_data, insns_elapsed
//   out_    | out | read_data, irq_fired
//
// Read, write, poll and disabled tick items go from ST_IDLE straight to ST_OUT.
// A tick slice goes through ST_DIV to start the 32-step serial divider and
// ST_WAIT to take its result; when it overflows it then goes through ST_MUL
// for the banked multiply and ST_UPD for the update.
// Reset is synchronous; one item is in flight at a time, and the result
// register holds while out_ready is low.
// ----------------------------------------------------------------------------
module upcounting_timer_with_prescaler (
  input logic      clk,
  input logic      rst_n,
  utp_in_if.sink   in_ch,
  utp_out_if.source out_ch
);
  import utp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_WAIT = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  logic [9:0]  ctl_r, ctl_nxt;
  logic [6:0]  ien_r, ien_nxt;
  logic        sr_r, sr_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [15:0] psc_r, psc_nxt;
  logic [31:0] arr_r, arr_nxt;
  logic [31:0] arrp_r, arrp_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] cc_r [4];
  logic [31:0] pw_r [7];
  logic [31:0] rd_r, rd_nxt;
  logic        irq_r, irq_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        fire;
  logic [31:0] rdv, to_ovf;
  logic [31:0] prod_w;
  logic        wr_en;
  logic [9:0]  wr_off;
  logic [31:0] wr_dat;
  div_req_t    dreq;
  div_rsp_t    drsp;

  utp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ch.ready      = (st_r == ST_IDLE);
  assign out_ch.valid     = (st_r == ST_OUT);
  assign out_ch.read_data = rd_r;
  assign out_ch.irq_fired = irq_r;

  always_comb begin
    unique case (in_ch.offset)
      OFF_CTL: rdv = {22'd0, ctl_r};
      OFF_PW0: rdv = pw_r[0];
      OFF_PW1: rdv = pw_r[1];
      OFF_IEN: rdv = {25'd0, ien_r};
      OFF_SR:  rdv = {31'd0, sr_r};
      OFF_PW2: rdv = pw_r[2];
      OFF_PW3: rdv = pw_r[3];
      OFF_PW4: rdv = pw_r[4];
      OFF_CNT: rdv = cnt_r;
      OFF_PSC: rdv = {16'd0, psc_r};
      OFF_ARR: rdv = ctl_r[CTL_ARPE] ? arrp_r : arr_r;
      OFF_CC0: rdv = cc_r[0];
      OFF_CC1: rdv = cc_r[1];
      OFF_CC2: rdv = cc_r[2];
      OFF_CC3: rdv = cc_r[3];
      OFF_PW5: rdv = pw_r[5];
      OFF_PW6: rdv = pw_r[6];
      default: rdv = '0;
    endcase
  end

  assign to_ovf = arr_r + 32'd1 - cnt_r;
  assign prod_w = left_r * {15'd0, dreq.divisor};

  always_comb begin
    st_nxt   = st_r;
    ctl_nxt  = ctl_r;
    ien_nxt  = ien_r;
    sr_nxt   = sr_r;
    cnt_nxt  = cnt_r;
    psc_nxt  = psc_r;
    arr_nxt  = arr_r;
    arrp_nxt = arrp_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    rd_nxt   = rd_r;
    irq_nxt  = irq_r;
    left_nxt = left_r;
    prod_nxt = prod_r;
    fire     = 1'b0;
    wr_en    = 1'b0;
    wr_off   = in_ch.offset;
    wr_dat   = in_ch.write_data;
    dreq.start    = 1'b0;
    dreq.dividend = acc_r;
    dreq.divisor  = {1'b0, psc_r} + 17'd1;
    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          rd_nxt  = '0;
          irq_nxt = 1'b0;
          st_nxt  = ST_OUT;
          unique case (op_t'(in_ch.opcode))
            OP_READ:  rd_nxt = rdv;
            OP_WRITE: begin
              wr_en = 1'b1;
              unique case (in_ch.offset)
                OFF_CTL: ctl_nxt = in_ch.write_data[9:0] & CTL_MASK;
                OFF_IEN: ien_nxt = in_ch.write_data[6:0] & IEN_MASK;
                OFF_SR:  sr_nxt = sr_r & in_ch.write_data[0];
                OFF_EGR: fire = in_ch.write_data[0];
                OFF_CNT: cnt_nxt = in_ch.write_data;
                OFF_PSC: begin
                  psc_nxt = in_ch.write_data[15:0];
                  acc_nxt = '0;
                end
                OFF_ARR: begin
                  if (ctl_r[CTL_ARPE]) arrp_nxt = in_ch.write_data;
                  else arr_nxt = in_ch.write_data;
                end
                default: ;
              endcase
            end
            OP_TICK: begin
              if (ctl_r[CTL_CEN] && arr_r != '0) begin
                acc_nxt = acc_r + in_ch.insns_elapsed;
                st_nxt  = ST_DIV;
              end
            end
            OP_POLL: begin
              irq_nxt  = pend_r;
              pend_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        dreq.start = 1'b1;
        st_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (drsp.done) begin
          acc_nxt = drsp.rem;
          if (drsp.quot == '0) begin
            st_nxt = ST_OUT;
          end else if (arr_r == ALL_ONES && cnt_r == '0) begin
            cnt_nxt = drsp.quot;
            st_nxt  = ST_OUT;
          end else if (drsp.quot < to_ovf) begin
            cnt_nxt = cnt_r + drsp.quot;
            st_nxt  = ST_OUT;
          end else begin
            left_nxt = drsp.quot - to_ovf;
            st_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = prod_w;
        st_nxt   = ST_UPD;
      end
      ST_UPD: begin
        acc_nxt = acc_r + prod_r;
        fire    = 1'b1;
        irq_nxt = ien_r[0];
        st_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (fire) begin
      cnt_nxt = '0;
      if (ctl_r[CTL_ARPE]) arr_nxt = arrp_r;
      if (!ctl_r[CTL_UDIS]) begin
        sr_nxt = 1'b1;
        if (ien_r[0]) pend_nxt = 1'b1;
      end
      if (ctl_r[CTL_OPM]) ctl_nxt[CTL_CEN] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ctl_r  <= '0;
      ien_r  <= '0;
      sr_r   <= 1'b0;
      cnt_r  <= '0;
      psc_r  <= '0;
      arr_r  <= ALL_ONES;
      arrp_r <= ALL_ONES;
      acc_r  <= '0;
      pend_r <= 1'b0;
      for (int i = 0; i < 4; i++) cc_r[i] <= '0;
      for (int i = 0; i < 7; i++) pw_r[i] <= '0;
    end else begin
      st_r   <= st_nxt;
      ctl_r  <= ctl_nxt;
      ien_r  <= ien_nxt;
      sr_r   <= sr_nxt;
      cnt_r  <= cnt_nxt;
      psc_r  <= psc_nxt;
      arr_r  <= arr_nxt;
      arrp_r <= arrp_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      if (wr_en) begin
        unique case (wr_off)
          OFF_PW0: pw_r[0] <= wr_dat;
          OFF_PW1: pw_r[1] <= wr_dat;
          OFF_PW2: pw_r[2] <= wr_dat;
          OFF_PW3: pw_r[3] <= wr_dat;
          OFF_PW4: pw_r[4] <= wr_dat;
          OFF_PW5: pw_r[5] <= wr_dat;
          OFF_PW6: pw_r[6] <= wr_dat;
          OFF_CC0: cc_r[0] <= wr_dat;
          OFF_CC1: cc_r[1] <= wr_dat;
          OFF_CC2: cc_r[2] <= wr_dat;
          OFF_CC3: cc_r[3] <= wr_dat;
          default: ;
        endcase
      end
    end
    rd_r   <= rd_nxt;
    irq_r  <= irq_nxt;
    left_r <= left_nxt;
    prod_r <= prod_nxt;
  end
endmodule
